### rtl/core/input_button_axis_tracker_top_assert.svh
// Assertion macros for the input tracker checker.
`ifndef INPUT_BUTTON_AXIS_TRACKER_TOP_ASSERT_SVH
`define INPUT_BUTTON_AXIS_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IBAT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibat_checker: property violated");

// Next-cycle implication, sampled on clk, off during reset.
`define IBAT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibat_checker: property violated");

`endif

### rtl/core/ibat_pkg.sv
// Types, constants and update functions shared by the input tracker modules.
package ibat_pkg;

    localparam int ONE_Q    = 16384;
    localparam int SNAP_Q   = 1638;
    localparam int RAMP_MUL = 5;

    typedef enum logic [1:0] {
        FN_TICK   = 2'd0,
        FN_BUTTON = 2'd1,
        FN_AXIS   = 2'd2,
        FN_QUERY  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_HELD     = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_RELEASED = 2'd3
    } btn_phase_t;

    typedef enum logic [1:0] {
        RD_IN_CHAN  = 2'd0,
        RD_ZERO     = 2'd1,
        RD_CNT_NEXT = 2'd2,
        RD_CHAN     = 2'd3
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_ZERO = 2'd0,
        WR_TICK = 2'd1,
        WR_EVT  = 2'd2
    } wr_sel_t;

    typedef enum logic {
        OUT_EVT = 1'b0,
        OUT_RD  = 1'b1
    } out_sel_t;

    typedef struct packed {
        logic [15:0]        holder;
        btn_phase_t         phase;
        logic signed [15:0] analog_x;
        logic signed [15:0] analog_y;
        logic signed [15:0] dcount_x;
        logic signed [15:0] dcount_y;
        logic signed [15:0] ecount_x;
        logic signed [15:0] ecount_y;
        logic signed [15:0] elevel_x;
        logic signed [15:0] elevel_y;
        logic signed [15:0] comb_x;
        logic signed [15:0] comb_y;
    } chan_rec_t;

    typedef struct packed {
        logic    load_in;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    out_load;
        out_sel_t out_sel;
    } ibat_cmd_t;

    typedef struct packed {
        logic in_tick;
        logic chan_ok;
        logic cnt_last;
        logic out_free;
    } ibat_sts_t;

    function automatic logic signed [15:0] sat_add16(logic signed [15:0] a,
                                                     logic signed [2:0] inc);
        logic signed [16:0] s;
        s = $signed({a[15], a}) + $signed({{14{inc[2]}}, inc});
        if (s > 17'sd32767)
            return 16'sh7FFF;
        else if (s < -17'sd32768)
            return 16'sh8000;
        else
            return s[15:0];
    endfunction

    function automatic logic signed [15:0] ramp_axis(logic signed [15:0] lvl,
                                                     logic signed [15:0] cnt,
                                                     logic [16:0] step);
        logic signed [18:0] tgt;
        logic signed [18:0] e;
        logic signed [18:0] d;
        logic signed [18:0] stx;
        stx = $signed({2'b00, step});
        if (cnt > 16'sd0)
            tgt = 19'(ONE_Q);
        else if (cnt < 16'sd0)
            tgt = -19'(ONE_Q);
        else
            tgt = '0;
        e = $signed({{3{lvl[15]}}, lvl});
        if (e < tgt)
            e = e + stx;
        else if (e > tgt)
            e = e - stx;
        d = e - tgt;
        if (d < 19'sd0)
            d = -d;
        if (d <= 19'(SNAP_Q))
            e = tgt;
        if (e > 19'sd32767)
            return 16'sh7FFF;
        else if (e < -19'sd32768)
            return 16'sh8000;
        else
            return e[15:0];
    endfunction

    function automatic logic signed [15:0] combine(logic signed [15:0] an,
                                                   logic signed [15:0] dc,
                                                   logic signed [15:0] em);
        logic signed [17:0] dv;
        logic signed [17:0] s;
        if (dc > 16'sd0)
            dv = 18'(ONE_Q);
        else if (dc < 16'sd0)
            dv = -18'(ONE_Q);
        else
            dv = '0;
        s = $signed({{2{an[15]}}, an}) + $signed({{2{em[15]}}, em}) + dv;
        if (s > 18'(ONE_Q))
            return 16'(ONE_Q);
        else if (s < -18'(ONE_Q))
            return -16'(ONE_Q);
        else
            return s[15:0];
    endfunction

    function automatic chan_rec_t tick_update(chan_rec_t r, logic [16:0] step);
        chan_rec_t n;
        n = r;
        case (r.phase)
            PH_PRESSED:  n.phase = PH_HELD;
            PH_RELEASED: n.phase = PH_IDLE;
            default:     n.phase = r.phase;
        endcase
        n.elevel_x = ramp_axis(r.elevel_x, r.ecount_x, step);
        n.elevel_y = ramp_axis(r.elevel_y, r.ecount_y, step);
        n.comb_x   = combine(r.analog_x, r.dcount_x, n.elevel_x);
        n.comb_y   = combine(r.analog_y, r.dcount_y, n.elevel_y);
        return n;
    endfunction

    function automatic chan_rec_t event_update(chan_rec_t r, func_t fn, logic down,
                                               logic is_x, logic signed [15:0] level,
                                               logic analog, logic emulated);
        chan_rec_t         n;
        logic [15:0]       h;
        logic signed [2:0] inc;
        n = r;
        case (fn)
            FN_BUTTON:
            begin
                if (down)
                begin
                    if (r.holder == 16'd0)
                        n.phase = PH_PRESSED;
                    if (r.holder != 16'hFFFF)
                        n.holder = r.holder + 16'd1;
                end
                else
                begin
                    h = (r.holder != 16'd0) ? r.holder - 16'd1 : 16'd0;
                    n.holder = h;
                    if (h == 16'd0)
                        n.phase = PH_RELEASED;
                end
            end
            FN_AXIS:
            begin
                if (analog)
                begin
                    if (is_x)
                        n.analog_x = level;
                    else
                        n.analog_y = level;
                end
                else if (!emulated)
                begin
                    // truncate toward zero: floor, then bump negatives with a fraction
                    inc = $signed({level[15], level[15:14]});
                    if (level[15] && (|level[13:0]))
                        inc = inc + 3'sd1;
                    if (is_x)
                        n.dcount_x = sat_add16(r.dcount_x, inc);
                    else
                        n.dcount_y = sat_add16(r.dcount_y, inc);
                end
                else
                begin
                    inc = (level > 16'sd0) ? 3'sd1 : -3'sd1;
                    if (is_x)
                        n.ecount_x = sat_add16(r.ecount_x, inc);
                    else
                        n.ecount_y = sat_add16(r.ecount_y, inc);
                end
            end
            default:
            begin
                n = r;
            end
        endcase
        return n;
    endfunction

endpackage

### rtl/core/ibat_ctrl.sv
// Sequencer for the input tracker: clearing pass, tick sweep, events and reports.
module ibat_ctrl
    import ibat_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_axis_tvalid,
    output logic      s_ready,
    input  ibat_sts_t sts,
    output ibat_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_EVT    = 6'b000100,
        S_TICK   = 6'b001000,
        S_RPT_RD = 6'b010000,
        S_RPT    = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.rd_sel   = RD_IN_CHAN;
        cmd.wr_en    = 1'b0;
        cmd.wr_sel   = WR_ZERO;
        cmd.cnt_clr  = 1'b0;
        cmd.cnt_inc  = 1'b0;
        cmd.out_load = 1'b0;
        cmd.out_sel  = OUT_EVT;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_ZERO;
                if (sts.cnt_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                    cmd.cnt_inc = 1'b1;
            end
            S_IDLE:
            begin
                s_ready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    cmd.rd_en   = 1'b1;
                    if (sts.in_tick)
                    begin
                        cmd.rd_sel  = RD_ZERO;
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_TICK;
                    end
                    else
                    begin
                        cmd.rd_sel = RD_IN_CHAN;
                        state_next = S_EVT;
                    end
                end
            end
            S_EVT:
            begin
                if (sts.out_free)
                begin
                    cmd.wr_en    = sts.chan_ok;
                    cmd.wr_sel   = WR_EVT;
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_EVT;
                    state_next   = S_IDLE;
                end
            end
            S_TICK:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_TICK;
                if (sts.cnt_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_RPT_RD;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RD_CNT_NEXT;
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_RPT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CHAN;
                state_next = S_RPT;
            end
            S_RPT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_RD;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/ibat_datapath.sv
// Channel state memory, update logic, sweep counter and result register.
module ibat_datapath
    import ibat_pkg::*;
#(
    parameter int NUM_CHANNELS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [39:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    input  ibat_cmd_t   cmd,
    output ibat_sts_t   sts
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);
    localparam logic [8:0] NUM_CH_W = 9'(NUM_CHANNELS);

    chan_rec_t mem [NUM_CHANNELS];
    chan_rec_t rd_q_reg;

    func_t              func_reg;
    logic [4:0]         chan_reg;
    logic               down_reg;
    logic               is_x_reg;
    logic signed [15:0] level_reg;
    logic               analog_reg;
    logic               emul_reg;
    logic [13:0]        delta_reg;

    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [39:0]      m_data_reg;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] chan_idx;
    chan_rec_t        wr_data;
    chan_rec_t        evt_rec;
    chan_rec_t        tick_rec;
    chan_rec_t        out_rec;
    logic [16:0]      step;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg   <= func_t'(s_axis_tuser);
            chan_reg   <= s_axis_tdata[4:0];
            down_reg   <= s_axis_tdata[5];
            is_x_reg   <= s_axis_tdata[6];
            level_reg  <= $signed(s_axis_tdata[22:7]);
            analog_reg <= s_axis_tdata[23];
            emul_reg   <= s_axis_tdata[24];
            delta_reg  <= s_axis_tdata[38:25];
        end
    end

    assign chan_idx = IDX_W'(chan_reg);
    assign step     = 17'(delta_reg) * 17'(RAMP_MUL);
    assign evt_rec  = event_update(rd_q_reg, func_reg, down_reg, is_x_reg, level_reg,
                                   analog_reg, emul_reg);
    assign tick_rec = tick_update(rd_q_reg, step);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_IN_CHAN:  rd_addr = IDX_W'(s_axis_tdata[4:0]);
            RD_ZERO:     rd_addr = '0;
            RD_CNT_NEXT: rd_addr = cnt_reg + IDX_W'(1);
            RD_CHAN:     rd_addr = chan_idx;
            default:     rd_addr = '0;
        endcase
        case (cmd.wr_sel)
            WR_ZERO:
            begin
                wr_addr = cnt_reg;
                wr_data = '0;
            end
            WR_TICK:
            begin
                wr_addr = cnt_reg;
                wr_data = tick_rec;
            end
            WR_EVT:
            begin
                wr_addr = chan_idx;
                wr_data = evt_rec;
            end
            default:
            begin
                wr_addr = cnt_reg;
                wr_data = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_q_reg <= mem[rd_addr];
    end

    always_comb
    begin
        if (cmd.cnt_clr)
            cnt_next = '0;
        else if (cmd.cnt_inc)
            cnt_next = cnt_reg + IDX_W'(1);
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // result register
    assign out_rec = (cmd.out_sel == OUT_RD) ? rd_q_reg : evt_rec;

    always_comb
    begin
        if (cmd.out_load)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (sts.chan_ok)
                m_data_reg <= {1'b0, out_rec.comb_y, out_rec.comb_x, out_rec.phase, chan_reg};
            else
                m_data_reg <= {35'd0, chan_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign sts.in_tick  = (func_t'(s_axis_tuser) == FN_TICK);
    assign sts.chan_ok  = ({4'b0000, chan_reg} < NUM_CH_W);
    assign sts.cnt_last = (cnt_reg == LAST_IDX);
    assign sts.out_free = !m_valid_reg || m_axis_tready;

endmodule

### rtl/core/input_button_axis_tracker_top.sv
// Top level of the per-channel button and axis tracker.
// Events and queries: the channel record is read, then updated, written back and the result
// registered; a result still waiting holds the sequencer before the next request is taken.
// Tick: every channel record is swept in turn, then the requested channel is read back
// and its result registered; one channel record read, updated and written per cycle.
// Reset: a clearing pass over all NUM_CHANNELS records zeroes the memory, tready low.
module input_button_axis_tracker_top
    import ibat_pkg::*;
#(
    parameter int NUM_CHANNELS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // chan[4:0], down[5], is_x[6], level[22:7], analog[23], emulated[24],
    // delta[38:25], zero[39]
    input  logic [39:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // chan_out[4:0], button_state[6:5], axis_x[22:7], axis_y[38:23], zero[39]
    output logic [39:0] m_axis_tdata
);

    ibat_cmd_t cmd;
    ibat_sts_t sts;

    ibat_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_ready       (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    ibat_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

### rtl/core/ibat_checker.sv
// Port-level checker for the input tracker, bound to the top level.
`include "input_button_axis_tracker_top_assert.svh"

module ibat_checker
#(
    parameter int NUM_CHANNELS = 32
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    localparam logic [8:0] NUM_CH_W = 9'(NUM_CHANNELS);

    // one request in flight at a time
    `IBAT_ASSERT_NXT(a_busy_after_req, (s_axis_tvalid && s_axis_tready), (!s_axis_tready))
    `IBAT_ASSERT_NXT(a_out_hold, (m_axis_tvalid && !m_axis_tready), (m_axis_tvalid && $stable(m_axis_tdata)))
    `IBAT_ASSERT_IMP(a_bad_chan_zero, (m_axis_tvalid && ({4'b0000, m_axis_tdata[4:0]} >= NUM_CH_W)), (m_axis_tdata[39:5] == 35'd0))
    `IBAT_ASSERT_IMP(a_axis_range, m_axis_tvalid, (($signed(m_axis_tdata[22:7]) <= 16'sd16384) && ($signed(m_axis_tdata[22:7]) >= -16'sd16384) && ($signed(m_axis_tdata[38:23]) <= 16'sd16384) && ($signed(m_axis_tdata[38:23]) >= -16'sd16384)))

endmodule

bind input_button_axis_tracker_top ibat_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_ibat_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
